>>> design/sjis_pkg.sv
// Shared types and constants for the Shift-JIS to UTF-16 stream decoder.
// Holds the command record passed from the front end to the back end.
// Used by every module of the decoder; depends on nothing else.
package sjis_pkg;

  // Code table geometry.
  localparam int TABLE_DEPTH = 65536;
  localparam int TABLE_AW    = $clog2(TABLE_DEPTH);

  // Command queue geometry.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Input operation codes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_BYTE  = 1'b1;

  // Byte classes.
  localparam logic [7:0] LEAD_A_LO = 8'h81;
  localparam logic [7:0] LEAD_A_HI = 8'h9f;
  localparam logic [7:0] LEAD_B_LO = 8'he0;
  localparam logic [7:0] LEAD_B_HI = 8'hfc;
  localparam logic [7:0] KANA_LO   = 8'ha0;
  localparam logic [7:0] KANA_HI   = 8'hdf;

  // Half-width katakana offset into the UTF-16 range.
  localparam logic [15:0] KANA_OFFSET = 16'hfec0;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_TERM = 2'd1,
    KIND_OVF  = 2'd2
  } kind_t;

  // One result to be delivered.
  typedef struct packed {
    kind_t       kind;
    logic [15:0] unit;        // unit value when not taken from the table
    logic        from_table;  // unit comes from the table read
    logic [15:0] pos;         // destination index
    logic [15:0] cnt;         // units written after this result
    logic        last;
  } res_t;

  // One command for the back end: a table write or one or two results.
  typedef struct packed {
    logic                is_write;
    logic [TABLE_AW-1:0] addr;
    logic [15:0]         wdata;
    res_t                r0;
    logic                has_r1;
    res_t                r1;
  } cmd_t;

endpackage

>>> design/sjis_to_utf16_stream_decoder.sv
// Top level of the Shift-JIS to UTF-16 stream decoder.
// Instantiates sjis_front, sjis_cmd_fifo and sjis_back; depends on sjis_pkg.
//
// The decoder takes one input transaction per cycle while in_stall is low:
// either a write into the 64K x 16 code table or one source byte. Every byte
// is classified in the cycle it is accepted; a command then passes a
// four-entry queue to the back end, which makes one single-port synchronous
// table access per cycle and presents results from a registered output stage.
// Sustained rate is one byte per cycle while out_stall is low, except that
// the last byte of a string that also yields a terminator holds the output
// stage for both results, one after the other. The table has no reset and no
// clearing pass; entries must be written before they are looked up. Table
// writes complete in queue order, so a lookup after a write sees it.
module sjis_to_utf16_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [15:0] table_index,
  input  logic [15:0] table_value,
  input  logic [7:0]  byte_value,
  input  logic        end_of_string,
  input  logic [15:0] capacity_units,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] code_unit,
  output logic [15:0] unit_position,
  output logic [1:0]  kind,
  output logic [16:0] total_bytes,
  output logic        last
);

  logic           accept;
  logic           push;
  sjis_pkg::cmd_t push_cmd;
  sjis_pkg::cmd_t head;
  logic           pop;
  logic           q_empty;
  logic           q_full;

  // Input handshake.
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  sjis_front u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .operation      (operation),
    .table_index    (table_index),
    .table_value    (table_value),
    .byte_value     (byte_value),
    .end_of_string  (end_of_string),
    .capacity_units (capacity_units),
    .push           (push),
    .cmd            (push_cmd)
  );

  sjis_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  sjis_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .empty         (q_empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .code_unit     (code_unit),
    .unit_position (unit_position),
    .kind          (kind),
    .total_bytes   (total_bytes),
    .last          (last)
  );

`ifndef ASSERT_OFF
  // An overflow rewrite always ends the string.
  a_ovf_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == sjis_pkg::KIND_OVF |-> last)
    else $error("overflow result without last");

  // A terminator carries a zero unit and ends the string.
  a_term_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == sjis_pkg::KIND_TERM |-> code_unit == 16'd0 && last)
    else $error("bad terminator result");

  // The queue cannot be full and empty at once.
  a_fifo_sane: assert property (@(posedge clk) disable iff (rst)
    !(q_full && q_empty))
    else $error("command queue full and empty");

  // Nothing is popped from an empty queue.
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_empty |-> !pop)
    else $error("pop from empty command queue");
`endif

endmodule

>>> design/sjis_front.sv
// Front end of the decoder: accepts input transactions, classifies bytes and
// tracks the string state, then emits commands into the queue.
// Depends on sjis_pkg.
module sjis_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic                           operation,
  input  logic [sjis_pkg::TABLE_AW-1:0]  table_index,
  input  logic [15:0]                    table_value,
  input  logic [7:0]                     byte_value,
  input  logic                           end_of_string,
  input  logic [15:0]                    capacity_units,
  output logic                           push,
  output sjis_pkg::cmd_t                 cmd
);

  logic [7:0]  held_lead, held_lead_next;
  logic        lead_pending, lead_pending_next;
  logic [15:0] units_written, units_written_next;
  logic        stopped, stopped_next;

  logic        is_lead;
  logic        is_kana;
  logic        have_char;
  logic        char_tab;
  logic [15:0] char_unit;
  logic [15:0] units_after;

  // String state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_lead     <= '0;
      lead_pending  <= 1'b0;
      units_written <= '0;
      stopped       <= 1'b0;
    end else begin
      held_lead     <= held_lead_next;
      lead_pending  <= lead_pending_next;
      units_written <= units_written_next;
      stopped       <= stopped_next;
    end
  end

  // Byte classification.
  assign is_lead = (byte_value >= sjis_pkg::LEAD_A_LO && byte_value <= sjis_pkg::LEAD_A_HI) ||
                   (byte_value >= sjis_pkg::LEAD_B_LO && byte_value <= sjis_pkg::LEAD_B_HI);
  assign is_kana = byte_value >= sjis_pkg::KANA_LO && byte_value <= sjis_pkg::KANA_HI;

  // Command build and next string state.
  always_comb begin
    cmd                = '0;
    push               = 1'b0;
    held_lead_next     = held_lead;
    lead_pending_next  = lead_pending;
    units_written_next = units_written;
    stopped_next       = stopped;
    have_char          = 1'b0;
    char_tab           = 1'b0;
    char_unit          = {8'h00, byte_value};
    units_after        = units_written + 16'd1;

    if (accept && operation == sjis_pkg::OP_WRITE) begin
      cmd.is_write = 1'b1;
      cmd.addr     = table_index;
      cmd.wdata    = table_value;
      push         = 1'b1;
    end else if (accept) begin
      if (stopped) begin
        // Bytes after a stop are dropped until the end of the string.
        if (end_of_string) begin
          stopped_next       = 1'b0;
          units_written_next = '0;
        end
      end else if (lead_pending) begin
        have_char         = 1'b1;
        char_tab          = 1'b1;
        cmd.addr          = {byte_value, held_lead};
        lead_pending_next = 1'b0;
        held_lead_next    = '0;
      end else if (units_written >= capacity_units) begin
        // No room for a new character: rewrite the previous unit and stop.
        cmd.r0.kind = sjis_pkg::KIND_OVF;
        cmd.r0.pos  = (units_written != 16'd0) ? units_written - 16'd1 : 16'd0;
        cmd.r0.cnt  = units_written;
        cmd.r0.last = 1'b1;
        push        = 1'b1;
        if (end_of_string) begin
          units_written_next = '0;
        end else begin
          stopped_next = 1'b1;
        end
      end else if (is_lead) begin
        if (end_of_string) begin
          // A lead byte at the end pairs with a zero trail.
          have_char = 1'b1;
          char_tab  = 1'b1;
          cmd.addr  = {8'h00, byte_value};
        end else begin
          held_lead_next    = byte_value;
          lead_pending_next = 1'b1;
        end
      end else if (is_kana) begin
        have_char = 1'b1;
        char_unit = {8'h00, byte_value} + sjis_pkg::KANA_OFFSET;
      end else begin
        have_char = 1'b1;
      end

      if (have_char) begin
        cmd.r0.kind        = sjis_pkg::KIND_CHAR;
        cmd.r0.unit        = char_unit;
        cmd.r0.from_table  = char_tab;
        cmd.r0.pos         = units_written;
        cmd.r0.cnt         = units_after;
        push               = 1'b1;
        units_written_next = units_after;
        if (end_of_string) begin
          // Terminator only if it still fits.
          if (units_after < capacity_units) begin
            cmd.has_r1    = 1'b1;
            cmd.r1.kind   = sjis_pkg::KIND_TERM;
            cmd.r1.pos    = units_after;
            cmd.r1.cnt    = units_after + 16'd1;
            cmd.r1.last   = 1'b1;
          end else begin
            cmd.r0.last = 1'b1;
          end
          held_lead_next     = '0;
          lead_pending_next  = 1'b0;
          units_written_next = '0;
          stopped_next       = 1'b0;
        end
      end
    end
  end

endmodule

>>> design/sjis_cmd_fifo.sv
// Short command queue between the decoder front end and back end.
// Holds sjis_pkg::cmd_t records; depends on sjis_pkg.
module sjis_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sjis_pkg::cmd_t push_cmd,
  input  logic           pop,
  output sjis_pkg::cmd_t head,
  output logic           empty,
  output logic           full
);

  sjis_pkg::cmd_t entries [sjis_pkg::FIFO_DEPTH];

  logic [sjis_pkg::FIFO_AW-1:0] wr_ptr;
  logic [sjis_pkg::FIFO_AW-1:0] rd_ptr;
  logic [sjis_pkg::FIFO_AW:0]   count;
  logic                         do_push;
  logic                         do_pop;

  assign empty   = count == '0;
  assign full    = count == (sjis_pkg::FIFO_AW+1)'(sjis_pkg::FIFO_DEPTH);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

>>> design/sjis_back.sv
// Back end of the decoder: executes queued commands against the code table
// memory; each byte command delivers one or two results via the output stage.
// Depends on sjis_pkg.
module sjis_back (
  input  logic           clk,
  input  logic           rst,
  input  sjis_pkg::cmd_t head,
  input  logic           empty,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [15:0]    code_unit,
  output logic [15:0]    unit_position,
  output logic [1:0]     kind,
  output logic [16:0]    total_bytes,
  output logic           last
);

  logic [15:0] code_table [sjis_pkg::TABLE_DEPTH];
  logic [15:0] rdata;

  // Output stage.
  logic           b_valid;
  logic           b_slot;
  sjis_pkg::res_t b_r0;
  sjis_pkg::res_t b_r1;
  logic           b_has_r1;
  sjis_pkg::res_t cur;
  logic           finishing;
  logic           b_free;
  logic           do_read;
  logic           do_write;

  assign finishing = b_valid && !out_stall && (b_slot || !b_has_r1);
  assign b_free    = !b_valid || finishing;
  assign pop       = !empty && (head.is_write || b_free);
  assign do_write  = pop && head.is_write;
  assign do_read   = pop && !head.is_write;

  // Code table: one write or one read per cycle, read data registered.
  always_ff @(posedge clk) begin
    if (do_write) begin
      code_table[head.addr] <= head.wdata;
    end
    if (do_read) begin
      rdata <= code_table[head.addr];
    end
  end

  // Output stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      b_slot  <= 1'b0;
    end else if (do_read) begin
      b_valid <= 1'b1;
      b_slot  <= 1'b0;
    end else if (finishing) begin
      b_valid <= 1'b0;
      b_slot  <= 1'b0;
    end else if (b_valid && !out_stall) begin
      b_slot <= 1'b1;
    end
  end

  // Output stage payload.
  always_ff @(posedge clk) begin
    if (do_read) begin
      b_r0     <= head.r0;
      b_r1     <= head.r1;
      b_has_r1 <= head.has_r1;
    end
  end

  // Result fields of the transaction on offer.
  assign cur           = b_slot ? b_r1 : b_r0;
  assign out_valid     = b_valid;
  assign code_unit     = cur.from_table ? rdata : cur.unit;
  assign unit_position = cur.pos;
  assign kind          = cur.kind;
  assign total_bytes   = {cur.cnt, 1'b0};
  assign last          = cur.last;

endmodule

>>> test/tb_sjis_to_utf16_stream_decoder.sv
`timescale 1ns / 100ps
// Testbench for sjis_to_utf16_stream_decoder: streams code table writes and Shift-JIS
// strings through the block and checks every UTF-16 result against a local predictor.
// Depends on sjis_pkg and the decoder RTL only.
module tb_sjis_to_utf16_stream_decoder;

  localparam int SOURCE_ITEMS = 1500;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 300;

  // One input transaction: a table write or one source byte.
  typedef struct packed {
    logic        op;
    logic [15:0] index;
    logic [15:0] value;
    logic [7:0]  b;
    logic        eos;
    logic [15:0] cap;
  } sjis_txn_t;

  // One expected UTF-16 result.
  typedef struct packed {
    logic [15:0]     unit;
    logic [15:0]     pos;
    sjis_pkg::kind_t kind;
    logic [16:0]     bytes;
    logic            fin;
  } utf16_unit_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        operation = sjis_pkg::OP_WRITE;
  logic [15:0] table_index = '0;
  logic [15:0] table_value = '0;
  logic [7:0]  byte_value = '0;
  logic        end_of_string = 1'b0;
  logic [15:0] capacity_units = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] code_unit;
  logic [15:0] unit_position;
  logic [1:0]  kind;
  logic [16:0] total_bytes;
  logic        last;

  sjis_to_utf16_stream_decoder dut (.*);

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Pending input transactions and the results they must produce.
  sjis_txn_t   feed_q[$];
  utf16_unit_t expected_units[$];

  // Predictor state: the code table and the string in progress.
  logic [15:0] sjis_map [0:65535];
  logic [7:0]  held_byte = '0;
  logic        lead_held = 1'b0;
  logic [15:0] units_out = '0;
  logic        str_stopped = 1'b0;

  // Generator bookkeeping: which table entries hold a value by now.
  bit          loaded [0:65535];
  logic [7:0]  gen_prev = '0;
  bit          gen_prev_lead = 1'b0;

  bit in_taken  = 1'b0;
  bit out_taken = 1'b0;
  int items_fed = 0;
  int units_checked = 0;
  int idle_cycles = 0;
  int fail_count = 0;
  int bytes_seen = 0;
  int strings_seen = 0;
  int writes_seen = 0;
  int overflows_seen = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  function automatic bit is_lead(input logic [7:0] b);
    return (b >= sjis_pkg::LEAD_A_LO && b <= sjis_pkg::LEAD_A_HI) ||
           (b >= sjis_pkg::LEAD_B_LO && b <= sjis_pkg::LEAD_B_HI);
  endfunction

  // Queue a table write with random filler in the unused fields.
  task automatic push_write(input logic [15:0] idx, input logic [15:0] val);
    sjis_txn_t t;
    t.op = sjis_pkg::OP_WRITE;
    t.index = idx;
    t.value = val;
    t.b = 8'($urandom);
    t.eos = 1'($urandom);
    t.cap = 16'($urandom);
    loaded[idx] = 1'b1;
    feed_q.push_back(t);
  endtask

  // Queue a source byte. Any entry that this byte might look up is written first,
  // so the block never reads a table entry that holds nothing yet.
  task automatic push_byte(input logic [7:0] b, input logic eos, input logic [15:0] cap);
    sjis_txn_t t;
    if (gen_prev_lead && !loaded[{b, gen_prev}])
      push_write({b, gen_prev}, 16'($urandom));
    if (eos && is_lead(b) && !loaded[{8'h00, b}])
      push_write({8'h00, b}, 16'($urandom));
    t.op = sjis_pkg::OP_BYTE;
    t.index = 16'($urandom);
    t.value = 16'($urandom);
    t.b = b;
    t.eos = eos;
    t.cap = cap;
    feed_q.push_back(t);
    gen_prev = b;
    gen_prev_lead = !eos && is_lead(b);
  endtask

  // Queue one string: mostly well-formed characters, or raw random bytes when noisy.
  task automatic gen_string(input bit noisy);
    int          len;
    int          mode;
    int          cls;
    bit          vary;
    bit          last_one;
    logic [15:0] cap;
    logic [15:0] c;
    logic [7:0]  lead;
    mode = $urandom_range(9);
    vary = (mode == 9);
    if (mode < 6)
      cap = 16'($urandom_range(12));
    else if (mode < 8)
      cap = 16'($urandom);
    else
      cap = 16'hffff;
    len = $urandom_range(10, 1);
    for (int k = 0; k < len; k++) begin
      last_one = (k == len - 1);
      c = vary ? 16'($urandom_range(8)) : cap;
      if (noisy) begin
        push_byte(8'($urandom), last_one, c);
      end else begin
        if ($urandom_range(99) < 3)
          push_write(16'($urandom), 16'($urandom));
        cls = $urandom_range(3);
        if (cls == 0) begin
          push_byte(($urandom_range(7) == 0) ? 8'($urandom_range(8'hff, 8'hfd))
                                             : 8'($urandom_range(8'h80, 0)), last_one, c);
        end else if (cls == 1) begin
          push_byte(8'($urandom_range(sjis_pkg::KANA_HI, sjis_pkg::KANA_LO)), last_one, c);
        end else begin
          lead = $urandom_range(1) ?
                 8'($urandom_range(sjis_pkg::LEAD_A_HI, sjis_pkg::LEAD_A_LO)) :
                 8'($urandom_range(sjis_pkg::LEAD_B_HI, sjis_pkg::LEAD_B_LO));
          if (last_one && $urandom_range(3) == 0) begin
            push_byte(lead, 1'b1, c);
          end else begin
            push_byte(lead, 1'b0, c);
            push_byte(8'($urandom), last_one, vary ? 16'($urandom_range(8)) : cap);
          end
        end
      end
    end
  endtask

  task automatic restart_string();
    held_byte = '0;
    lead_held = 1'b0;
    units_out = '0;
    str_stopped = 1'b0;
  endtask

  task automatic queue_unit(input logic [15:0] unit, input logic [15:0] pos,
                            input sjis_pkg::kind_t k, input logic fin);
    utf16_unit_t u;
    u.unit = unit;
    u.pos = pos;
    u.kind = k;
    u.bytes = {units_out, 1'b0};
    u.fin = fin;
    expected_units.push_back(u);
  endtask

  // Predict the results of one accepted transaction.
  task automatic decode_sjis_item(input sjis_txn_t t);
    logic [15:0] ch;
    logic        have_ch;
    have_ch = 1'b0;
    ch = '0;
    if (t.op == sjis_pkg::OP_WRITE) begin
      sjis_map[t.index] = t.value;
      writes_seen++;
      return;
    end
    bytes_seen++;
    if (t.eos)
      strings_seen++;
    // After a stop, bytes are dropped until the end of the string.
    if (str_stopped) begin
      if (t.eos)
        restart_string();
      return;
    end
    if (lead_held) begin
      // A trail byte completes the pair; it makes no capacity check.
      ch = sjis_map[{t.b, held_byte}];
      lead_held = 1'b0;
      held_byte = '0;
      have_ch = 1'b1;
    end else begin
      // Out of room as a character starts: zero the previous unit and stop.
      if (units_out >= t.cap) begin
        queue_unit(16'h0000, (units_out != 0) ? units_out - 16'd1 : 16'd0,
                   sjis_pkg::KIND_OVF, 1'b1);
        overflows_seen++;
        if (t.eos)
          restart_string();
        else
          str_stopped = 1'b1;
        return;
      end
      if (is_lead(t.b)) begin
        // A lead byte at the end of the string pairs with a zero trail.
        if (t.eos) begin
          ch = sjis_map[{8'h00, t.b}];
          have_ch = 1'b1;
        end else begin
          held_byte = t.b;
          lead_held = 1'b1;
        end
      end else if (t.b >= sjis_pkg::KANA_LO && t.b <= sjis_pkg::KANA_HI) begin
        ch = {8'h00, t.b} + sjis_pkg::KANA_OFFSET;
        have_ch = 1'b1;
      end else begin
        ch = {8'h00, t.b};
        have_ch = 1'b1;
      end
    end
    if (have_ch) begin
      units_out++;
      queue_unit(ch, units_out - 16'd1, sjis_pkg::KIND_CHAR, t.eos && units_out >= t.cap);
    end
    // Terminator only when room is left for it.
    if (t.eos) begin
      if (units_out < t.cap) begin
        units_out++;
        queue_unit(16'h0000, units_out - 16'd1, sjis_pkg::KIND_TERM, 1'b1);
      end
      restart_string();
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // Stimulus and end of run.
  initial begin : stimulus
    int r;
    // Directed strings: every byte class with roomy capacity, a lead byte at the end.
    push_byte(8'h00, 1'b0, 16'hffff);
    push_byte(8'h7f, 1'b0, 16'hffff);
    push_byte(8'h80, 1'b0, 16'hffff);
    push_byte(8'ha0, 1'b0, 16'hffff);
    push_byte(8'hdf, 1'b0, 16'hffff);
    push_byte(8'hfd, 1'b0, 16'hffff);
    push_byte(8'h81, 1'b0, 16'hffff);
    push_byte(8'h40, 1'b0, 16'hffff);
    push_byte(8'hfc, 1'b0, 16'hffff);
    push_byte(8'hff, 1'b0, 16'hffff);
    push_byte(8'he0, 1'b1, 16'hffff);
    // Zero capacity: a stop before anything was written.
    push_byte(8'h41, 1'b1, 16'h0000);
    // Pair with a zero trail and a table write between lead and trail, then an
    // overflow, bytes ignored after the stop, and the end that clears it.
    push_byte(8'h41, 1'b0, 16'd2);
    push_byte(8'h9f, 1'b0, 16'd2);
    push_byte(8'h00, 1'b0, 16'd2);
    push_byte(8'h42, 1'b0, 16'd2);
    push_byte(8'h43, 1'b0, 16'd2);
    push_byte(8'h44, 1'b1, 16'd2);
    // Trail byte ignores its own capacity; no room left for the terminator.
    push_byte(8'h81, 1'b0, 16'd1);
    push_byte(8'h40, 1'b1, 16'd0);

    // Random strings, noisy strings and stray table writes.
    while (feed_q.size() < SOURCE_ITEMS) begin
      r = $urandom_range(99);
      if (r < 5)
        push_write(16'($urandom), 16'($urandom));
      else
        gen_string(r >= 87);
    end

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    while (feed_q.size() != 0)
      @(posedge clk);
    while (expected_units.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d strings of %0d source bytes with %0d table writes;",
             strings_seen, bytes_seen, writes_seen);
    $display("checked %0d code units, %0d of them overflow stops.",
             units_checked, overflows_seen);
    if (fail_count == 0 && expected_units.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Input driver: hold a stalled transaction, otherwise offer the next one or idle.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (feed_q.size() != 0 &&
          ((items_fed >= 500 && items_fed < 800) || $urandom_range(99) >= 15)) begin
        in_valid       <= 1'b1;
        operation      <= feed_q[0].op;
        table_index    <= feed_q[0].index;
        table_value    <= feed_q[0].value;
        byte_value     <= feed_q[0].b;
        end_of_string  <= feed_q[0].eos;
        capacity_units <= feed_q[0].cap;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output stall: one long hold-off to back the block up, random stalls elsewhere.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!hold_done && units_checked >= 150) begin
      out_stall <= 1'b1;
      hold_left = HOLD_CYCLES - 1;
      hold_done = 1'b1;
    end else begin
      out_stall <= !(units_checked >= 400 && units_checked < 800) &&
                   ($urandom_range(99) < 15);
    end
  end

  // Accept side: predict on every input transaction, check every result, watchdog.
  always @(posedge clk) begin : monitor
    sjis_txn_t   t;
    utf16_unit_t want;
    in_taken  = !rst && in_valid && !in_stall;
    out_taken = !rst && out_valid && !out_stall;
    if (in_taken) begin
      t = feed_q.pop_front();
      decode_sjis_item(t);
      items_fed++;
    end
    if (out_taken) begin
      if (expected_units.size() == 0) begin
        $error("unexpected result: code_unit %0h at position %0d", code_unit, unit_position);
        fail_count++;
      end else begin
        want = expected_units.pop_front();
        check_field("code_unit", 32'(want.unit), 32'(code_unit));
        check_field("unit_position", 32'(want.pos), 32'(unit_position));
        check_field("kind", 32'(want.kind), 32'(kind));
        check_field("total_bytes", 32'(want.bytes), 32'(total_bytes));
        check_field("last", 32'(want.fin), 32'(last));
      end
      units_checked++;
    end
    // Stop the run if nothing moves for too long.
    if (in_taken || out_taken)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule
